@@ rtl/text_console_writer_core_defines.svh @@
// ----------------------------------------------------------------------------
// text console writer assertion macros
// concurrent assertion helpers for the console engine, sampled on clk,
// held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define TCW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TCW_ASSERT(label, prop, msg)
`define TCW_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// text console writer package
// screen geometry, character codes, opcodes and controller/datapath types
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	localparam int unsigned COLUMNS   = 80;
	localparam int unsigned ROWS      = 25;
	localparam int unsigned TAB_STOP  = 8;
	localparam int unsigned CELLS     = ROWS * COLUMNS;
	localparam int unsigned ADDR_W    = $clog2(CELLS);
	localparam int unsigned ROW_W     = 5;
	localparam int unsigned COL_W     = 7;
	localparam int unsigned CHAR_W    = 8;
	localparam int unsigned COLOR_W   = 4;
	localparam int unsigned CELL_W    = 16;
	localparam int unsigned OP_W      = 2;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [OP_W-1:0] OP_PUT_CHAR = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR    = 2'd1;
	localparam logic [OP_W-1:0] OP_READ     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 1'd1;

	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

	localparam logic [CELL_W-1:0]  RESET_CELL = 16'h0720;
	localparam logic [COLOR_W-1:0] FG_RESET   = 4'd7;
	localparam logic [COLOR_W-1:0] BG_RESET   = 4'd0;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_SCROLL,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		SW_INIT,
		SW_CLEAR,
		SW_SCROLL
	} sweep_kind_t;

	typedef struct packed {
		logic        accept;
		logic        load_out;
		logic        from_done;
		logic        sweep_we;
		sweep_kind_t sweep_kind;
		logic        sweep_end;
	} cmd_t;

	typedef struct packed {
		logic needs_scroll;
		logic last_row;
		logic last_cell;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

@@ rtl/text_console_writer_core.sv @@
// ----------------------------------------------------------------------------
// text console writer core
// 25x80 text-mode console: character output, clear and cell readback
// ----------------------------------------------------------------------------
// After reset the screen memory is swept to grey blanks, one cell a cycle,
// with in_stall high; color writes are taken at any time. Then a character,
// return, tab or backspace that needs no scroll, or the unused opcode, loads
// the result register as it is taken; a cell read passes through ST_DONE
// (registered memory read). A scroll blanks the old top row one cell a cycle,
// then the top-row pointer of the circular screen advances so that row is the
// bottom row; a clear blanks every cell one cell a cycle, as the screen memory
// has a single write port. Results sit in an output register, so a new item is
// taken in the same cycle the previous result transfers.
`default_nettype none

module text_console_writer_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_stall,
	input  wire logic [tcw_pkg::OP_W-1:0]      opcode,
	input  wire logic [tcw_pkg::CHAR_W-1:0]    char_code,
	input  wire logic [tcw_pkg::ROW_W-1:0]     read_row,
	input  wire logic [tcw_pkg::COL_W-1:0]     read_col,
	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      logic [tcw_pkg::ROW_W-1:0]     cursor_row,
	output      logic [tcw_pkg::COL_W-1:0]     cursor_col,
	output      logic [tcw_pkg::CELL_W-1:0]    cell_value,
	output      logic                          scrolled,
	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tcw_pkg::COLOR_W-1:0]   cfg_data
);

	import tcw_pkg::*;

	cmd_t    cmd;
	status_t status;

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.status   (status),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	tcw_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.opcode     (opcode),
		.char_code  (char_code),
		.read_row   (read_row),
		.read_col   (read_col),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col),
		.cell_value (cell_value),
		.scrolled   (scrolled)
	);

endmodule

`default_nettype wire

@@ rtl/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw controller
// sequences item acceptance, memory sweeps and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_writer_core_defines.svh"

module tcw_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic [tcw_pkg::OP_W-1:0] opcode,
	input  wire tcw_pkg::status_t         status,
	output      tcw_pkg::cmd_t            cmd,
	output      logic                     in_stall
);

	import tcw_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (status.last_cell) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid && status.out_free) begin
					case (opcode)
						OP_PUT_CHAR: begin
							if (status.needs_scroll) state_d = ST_SCROLL;
						end
						OP_CLEAR: state_d = ST_CLEAR;
						OP_READ:  state_d = ST_DONE;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR: begin
				if (status.last_cell) state_d = ST_DONE;
			end
			ST_SCROLL: begin
				if (status.last_row) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd            = '0;
		cmd.sweep_kind = SW_INIT;
		in_stall       = 1'b1;
		case (state_q)
			ST_INIT: begin
				cmd.sweep_we   = 1'b1;
				cmd.sweep_kind = SW_INIT;
				cmd.sweep_end  = status.last_cell;
			end
			ST_IDLE: begin
				in_stall   = !status.out_free;
				cmd.accept = in_valid && status.out_free;
				if (cmd.accept) begin
					case (opcode)
						OP_PUT_CHAR: cmd.load_out = !status.needs_scroll;
						OP_CLEAR:    cmd.load_out = 1'b0;
						OP_READ:     cmd.load_out = 1'b0;
						default:     cmd.load_out = 1'b1;
					endcase
				end
			end
			ST_CLEAR: begin
				cmd.sweep_we   = 1'b1;
				cmd.sweep_kind = SW_CLEAR;
				cmd.sweep_end  = status.last_cell;
			end
			ST_SCROLL: begin
				cmd.sweep_we   = 1'b1;
				cmd.sweep_kind = SW_SCROLL;
				cmd.sweep_end  = status.last_row;
			end
			ST_DONE: begin
				cmd.load_out  = status.out_free;
				cmd.from_done = 1'b1;
			end
			default: begin
				cmd.load_out = 1'b0;
			end
		endcase
	end

	`TCW_ASSERT(a_load_has_room, !cmd.load_out || status.out_free, "result register overrun")
	`TCW_ASSERT_NEXT(a_scroll_ends, state_q == ST_SCROLL && status.last_row, state_q == ST_DONE, "scroll did not finish")

endmodule

`default_nettype wire

@@ rtl/tcw_datapath.sv @@
// ----------------------------------------------------------------------------
// tcw datapath
// cursor, screen memory with rotating top row, sweep counter, result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_writer_core_defines.svh"

module tcw_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tcw_pkg::cmd_t                 cmd,
	output      tcw_pkg::status_t              status,
	input  wire logic [tcw_pkg::OP_W-1:0]      opcode,
	input  wire logic [tcw_pkg::CHAR_W-1:0]    char_code,
	input  wire logic [tcw_pkg::ROW_W-1:0]     read_row,
	input  wire logic [tcw_pkg::COL_W-1:0]     read_col,
	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tcw_pkg::COLOR_W-1:0]   cfg_data,
	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      logic [tcw_pkg::ROW_W-1:0]     cursor_row,
	output      logic [tcw_pkg::COL_W-1:0]     cursor_col,
	output      logic [tcw_pkg::CELL_W-1:0]    cell_value,
	output      logic                          scrolled
);

	import tcw_pkg::*;

	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   top_q;
	logic [ADDR_W-1:0]  cnt_q;
	logic [COLOR_W-1:0] fg_q;
	logic [COLOR_W-1:0] bg_q;
	logic               pend_read_q;
	logic               pend_scroll_q;
	logic               out_valid_q;
	logic [ROW_W-1:0]   out_row_q;
	logic [COL_W-1:0]   out_col_q;
	logic [CELL_W-1:0]  out_cell_q;
	logic               out_scrolled_q;

	logic [ROW_W-1:0]   ch_row;
	logic [COL_W-1:0]   ch_col;
	logic [ROW_W-1:0]   wr_row;
	logic [COL_W-1:0]   wr_col;
	logic [CHAR_W-1:0]  wr_char;
	logic               char_we;
	logic               new_line;
	logic               needs_scroll;
	logic [COL_W:0]     tab_col;
	logic [COL_W:0]     inc_col;

	logic [ROW_W-1:0]   row_n;
	logic [COL_W-1:0]   col_n;
	logic [ROW_W-1:0]   top_n;

	logic [ROW_W-1:0]   sel_row;
	logic [COL_W-1:0]   sel_col;
	logic [ROW_W:0]     phys_sum;
	logic [ROW_W-1:0]   phys_row;
	logic [ADDR_W-1:0]  cell_addr;
	logic [ADDR_W-1:0]  sweep_addr;
	logic [ADDR_W-1:0]  ram_addr;
	logic [CELL_W-1:0]  ram_wdata;
	logic [CELL_W-1:0]  ram_rdata;
	logic               ram_we;
	logic               ram_re;
	logic               rd_ok;
	logic [7:0]         attr;
	logic               out_free;

	assign attr      = {bg_q, fg_q};
	assign cfg_ready = 1'b1;

	// character handling
	always_comb begin
		ch_row   = row_q;
		ch_col   = col_q;
		wr_row   = row_q;
		wr_col   = col_q;
		wr_char  = char_code;
		char_we  = 1'b0;
		new_line = 1'b0;
		needs_scroll = 1'b0;
		tab_col  = (COL_W+1)'(col_q) + (COL_W+1)'(TAB_STOP)
			- (COL_W+1)'(col_q % TAB_STOP);
		inc_col  = (COL_W+1)'(col_q) + (COL_W+1)'(1);
		case (char_code)
			CH_NEWLINE: begin
				new_line = 1'b1;
			end
			CH_RETURN: begin
				ch_col = '0;
			end
			CH_TAB: begin
				if (tab_col >= (COL_W+1)'(COLUMNS)) new_line = 1'b1;
				else ch_col = COL_W'(tab_col);
			end
			CH_BACKSPACE: begin
				if (col_q != '0) begin
					ch_col  = col_q - COL_W'(1);
					wr_col  = col_q - COL_W'(1);
					wr_char = CH_SPACE;
					char_we = 1'b1;
				end else if (row_q != '0) begin
					ch_row  = row_q - ROW_W'(1);
					ch_col  = COL_W'(COLUMNS - 1);
					wr_row  = row_q - ROW_W'(1);
					wr_col  = COL_W'(COLUMNS - 1);
					wr_char = CH_SPACE;
					char_we = 1'b1;
				end
			end
			default: begin
				char_we = 1'b1;
				if (inc_col >= (COL_W+1)'(COLUMNS)) new_line = 1'b1;
				else ch_col = COL_W'(inc_col);
			end
		endcase
		if (new_line) begin
			ch_col = '0;
			if (row_q == ROW_W'(ROWS - 1)) needs_scroll = 1'b1;
			else ch_row = row_q + ROW_W'(1);
		end
	end

	// next cursor and top row
	always_comb begin
		row_n = row_q;
		col_n = col_q;
		top_n = top_q;
		if (cmd.accept) begin
			case (opcode)
				OP_PUT_CHAR: begin
					row_n = ch_row;
					col_n = ch_col;
				end
				OP_CLEAR: begin
					row_n = '0;
					col_n = '0;
					top_n = '0;
				end
				default: begin
					row_n = row_q;
				end
			endcase
		end
		if (cmd.sweep_we && cmd.sweep_end && cmd.sweep_kind == SW_SCROLL) begin
			top_n = (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + ROW_W'(1);
		end
	end

	// screen address generation
	assign rd_ok    = (read_row < ROW_W'(ROWS)) && (read_col < COL_W'(COLUMNS));
	assign sel_row  = (opcode == OP_READ) ? read_row : wr_row;
	assign sel_col  = (opcode == OP_READ) ? read_col : wr_col;
	assign phys_sum = (ROW_W+1)'(sel_row) + (ROW_W+1)'(top_q);
	assign phys_row = (phys_sum >= (ROW_W+1)'(ROWS))
		? ROW_W'(phys_sum - (ROW_W+1)'(ROWS)) : ROW_W'(phys_sum);
	assign cell_addr = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(sel_col);

	always_comb begin
		case (cmd.sweep_kind)
			SW_SCROLL: sweep_addr = ADDR_W'(top_q) * ADDR_W'(COLUMNS) + cnt_q;
			default:   sweep_addr = cnt_q;
		endcase
	end

	always_comb begin
		if (cmd.sweep_we) begin
			ram_addr = sweep_addr;
			if (cmd.sweep_kind == SW_INIT) ram_wdata = RESET_CELL;
			else ram_wdata = {attr, CH_SPACE};
		end else begin
			ram_addr  = cell_addr;
			ram_wdata = {attr, wr_char};
		end
	end

	assign ram_we = cmd.sweep_we || (cmd.accept && opcode == OP_PUT_CHAR && char_we);
	assign ram_re = cmd.accept && opcode == OP_READ && rd_ok;

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q         <= '0;
			col_q         <= '0;
			top_q         <= '0;
			cnt_q         <= '0;
			fg_q          <= FG_RESET;
			bg_q          <= BG_RESET;
			pend_read_q   <= 1'b0;
			pend_scroll_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			row_q <= row_n;
			col_q <= col_n;
			top_q <= top_n;
			if (cmd.sweep_we) begin
				cnt_q <= cmd.sweep_end ? '0 : cnt_q + ADDR_W'(1);
			end
			if (cfg_valid) begin
				case (cfg_index)
					CFG_FG_COLOR: fg_q <= cfg_data;
					CFG_BG_COLOR: bg_q <= cfg_data;
					default:      fg_q <= fg_q;
				endcase
			end
			if (cmd.accept) begin
				pend_read_q   <= (opcode == OP_READ) && rd_ok;
				pend_scroll_q <= (opcode == OP_PUT_CHAR) && needs_scroll;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_row_q      <= row_n;
			out_col_q      <= col_n;
			out_cell_q     <= (cmd.from_done && pend_read_q) ? ram_rdata : '0;
			out_scrolled_q <= cmd.from_done && pend_scroll_q;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	assign status.needs_scroll = needs_scroll;
	assign status.last_row     = (cnt_q == ADDR_W'(COLUMNS - 1));
	assign status.last_cell    = (cnt_q == ADDR_W'(CELLS - 1));
	assign status.out_free     = out_free;

	assign out_valid  = out_valid_q;
	assign cursor_row = out_row_q;
	assign cursor_col = out_col_q;
	assign cell_value = out_cell_q;
	assign scrolled   = out_scrolled_q;

	`TCW_ASSERT(a_cursor_range, row_q < ROW_W'(ROWS) && col_q < COL_W'(COLUMNS), "cursor off screen")
	`TCW_ASSERT(a_top_range, top_q < ROW_W'(ROWS), "top row pointer out of range")

endmodule

`default_nettype wire
